@@ rtl/dcwh_pkg.sv @@
// Shared constants, codes, item type and bit-count helper for the
// dual code weight histogram. No dependencies.
`default_nettype none

package dcwh_pkg;

    localparam int CHECK_BITS    = 30;
    localparam int COLUMNS       = 512;
    localparam int COLS_PER_CELL = 32;
    localparam int CELLS         = COLUMNS / COLS_PER_CELL;
    localparam int CELL_ID_W     = $clog2(CELLS);
    localparam int CELL_COL_W    = $clog2(COLS_PER_CELL);
    localparam int HIST_DEPTH    = CHECK_BITS + COLUMNS + 1;
    localparam int HIST_AW       = $clog2(HIST_DEPTH);

    localparam int CMD_W     = 2;
    localparam int COL_IDX_W = 9;
    localparam int WEIGHT_W  = 10;
    localparam int BIN_W     = 10;
    localparam int COUNT_W   = 30;
    localparam int UCOLS_W   = 10;
    localparam int UBITS_W   = 5;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [COUNT_W-1:0] BIN_MAX = {COUNT_W{1'b1}};

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_COUNT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    localparam logic REG_USED_COLUMNS    = 1'b0;
    localparam logic REG_USED_CHECK_BITS = 1'b1;

    // One request as it travels down the row of cells
    typedef struct packed {
        logic [CMD_W-1:0]      kind;
        logic [COL_IDX_W-1:0]  col_idx;
        logic [CHECK_BITS-1:0] col_val;
        logic [CHECK_BITS-1:0] word;
        logic [WEIGHT_W-1:0]   weight;
        logic [BIN_W-1:0]      bin;
    } dcwh_item_t;

    typedef struct packed {
        logic clearing;
        logic take;
    } dcwh_hist_status_t;

    // Balanced adder tree over 32 bits
    function automatic logic [5:0] ones32(input logic [31:0] v);
        logic [1:0] s1 [16];
        logic [2:0] s2 [8];
        logic [3:0] s3 [4];
        logic [4:0] s4 [2];
        for (int i = 0; i < 16; i++)
        begin
            s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        end
        for (int i = 0; i < 8; i++)
        begin
            s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
        end
        for (int i = 0; i < 4; i++)
        begin
            s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
        end
        for (int i = 0; i < 2; i++)
        begin
            s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
        end
        return {1'b0, s4[0]} + {1'b0, s4[1]};
    endfunction

endpackage

`default_nettype wire

@@ rtl/dcwh_if.sv @@
// Request and result channel interfaces with valid/ready handshake.
// Depends on dcwh_pkg for field widths.
`default_nettype none

interface dcwh_cmd_if import dcwh_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CMD_W-1:0]      cmd;
    logic [COL_IDX_W-1:0]  column_index;
    logic [CHECK_BITS-1:0] column_value;
    logic [CHECK_BITS-1:0] word;
    logic [BIN_W-1:0]      bin_index;

    modport source (output valid, cmd, column_index, column_value, word, bin_index,
                    input ready);
    modport sink   (input valid, cmd, column_index, column_value, word, bin_index,
                    output ready);
endinterface

interface dcwh_res_if import dcwh_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [WEIGHT_W-1:0] weight;
    logic [COUNT_W-1:0]  bin_count;
    logic                saturated;

    modport source (output valid, weight, bin_count, saturated, input ready);
    modport sink   (input valid, weight, bin_count, saturated, output ready);
endinterface

`default_nettype wire

@@ rtl/dcwh_cell.sv @@
// One cell of the column row: holds a slice of columns, adds their parities
// to a passing count request and captures column loads aimed at it. Uses dcwh_pkg.
`default_nettype none

module dcwh_cell import dcwh_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [CELL_ID_W-1:0] cell_id,
    input  wire logic [UCOLS_W-1:0]   used_cols,
    input  wire logic                 adv,
    input  wire logic                 up_valid,
    input  wire dcwh_item_t           up_item,
    output logic                      dn_valid,
    output dcwh_item_t                dn_item
);

    logic [CHECK_BITS-1:0] cols_reg [COLS_PER_CELL];
    logic                  valid_reg;
    dcwh_item_t            item_reg;
    dcwh_item_t            item_next;
    logic [31:0]           par;
    logic                  load_here;

    always_comb
    begin
        par = '0;
        for (int j = 0; j < COLS_PER_CELL; j++)
        begin
            par[j] = (^(up_item.word & cols_reg[j]))
                     && ({1'b0, cell_id, CELL_COL_W'(j)} < used_cols);
        end
    end

    always_comb
    begin
        item_next = up_item;
        if (up_item.kind == CMD_COUNT)
        begin
            item_next.weight = up_item.weight + {{(WEIGHT_W-6){1'b0}}, ones32(par)};
        end
    end

    assign load_here = adv && up_valid && (up_item.kind == CMD_LOAD)
                       && (up_item.col_idx[COL_IDX_W-1:CELL_COL_W] == cell_id);

    // Column store: written as the load passes, read at fixed places
    always_ff @(posedge clk)
    begin
        if (load_here)
        begin
            cols_reg[up_item.col_idx[CELL_COL_W-1:0]] <= up_item.col_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && up_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

endmodule

`default_nettype wire

@@ rtl/dcwh_hist.sv @@
// Histogram memory with clearing pass, read-modify-write stage and output
// register. Uses dcwh_pkg and the result channel interface.
`default_nettype none

module dcwh_hist import dcwh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        up_valid,
    input  wire dcwh_item_t  up_item,
    output dcwh_hist_status_t status,
    dcwh_res_if.source       result
);

    logic [COUNT_W-1:0] hist_mem [HIST_DEPTH];
    logic [COUNT_W-1:0] rd_data_reg;

    logic               clearing_reg;
    logic [HIST_AW-1:0] clr_idx_reg;

    logic               m_valid_reg;
    logic [CMD_W-1:0]   m_kind_reg;
    logic [WEIGHT_W-1:0] m_weight_reg;
    logic [HIST_AW-1:0] m_addr_reg;
    logic               m_range_reg;

    logic               fwd_valid_reg;
    logic [HIST_AW-1:0] fwd_addr_reg;
    logic [COUNT_W-1:0] fwd_data_reg;

    logic                res_valid_reg;
    logic [WEIGHT_W-1:0] res_weight_reg;
    logic [COUNT_W-1:0]  res_count_reg;
    logic                res_sat_reg;

    logic               out_adv;
    logic               take;
    logic               leave;
    logic               up_range;
    logic [HIST_AW-1:0] up_addr;
    logic               re;
    logic               we;
    logic [HIST_AW-1:0] wa;
    logic [COUNT_W-1:0] wd;
    logic [COUNT_W-1:0] cur;
    logic [COUNT_W-1:0] inc;

    assign out_adv = !res_valid_reg || result.ready;
    assign take    = !m_valid_reg || out_adv;
    assign leave   = m_valid_reg && out_adv;

    always_comb
    begin
        up_range = 1'b0;
        up_addr  = '0;
        case (up_item.kind)
            CMD_COUNT:
            begin
                up_range = 1'b1;
                up_addr  = up_item.weight[HIST_AW-1:0];
            end
            CMD_READ:
            begin
                up_range = ({1'b0, up_item.bin} < (BIN_W+1)'(HIST_DEPTH));
                up_addr  = up_item.bin[HIST_AW-1:0];
            end
            default:
            begin
                up_range = 1'b0;
                up_addr  = '0;
            end
        endcase
    end

    assign re = take && up_valid && up_range;

    // Latest write wins over a read taken at the same edge
    assign cur = (fwd_valid_reg && (fwd_addr_reg == m_addr_reg)) ? fwd_data_reg
                                                                 : rd_data_reg;
    assign inc = (cur == BIN_MAX) ? cur : cur + COUNT_W'(1);

    assign we = clearing_reg || (leave && (m_kind_reg == CMD_COUNT));
    assign wa = clearing_reg ? clr_idx_reg : m_addr_reg;
    assign wd = clearing_reg ? '0 : inc;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            hist_mem[wa] <= wd;
        end
        if (re)
        begin
            rd_data_reg <= hist_mem[up_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            m_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_idx_reg <= clr_idx_reg + HIST_AW'(1);
                if (clr_idx_reg == HIST_AW'(HIST_DEPTH - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (take)
            begin
                m_valid_reg <= up_valid;
            end
            if (leave && (m_kind_reg == CMD_COUNT))
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (out_adv)
            begin
                res_valid_reg <= m_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && up_valid)
        begin
            m_kind_reg   <= up_item.kind;
            m_weight_reg <= up_item.weight;
            m_addr_reg   <= up_addr;
            m_range_reg  <= up_range;
        end
        if (leave && (m_kind_reg == CMD_COUNT))
        begin
            fwd_addr_reg <= m_addr_reg;
            fwd_data_reg <= inc;
        end
        if (leave)
        begin
            case (m_kind_reg)
                CMD_COUNT:
                begin
                    res_weight_reg <= m_weight_reg;
                    res_count_reg  <= '0;
                    res_sat_reg    <= (inc == BIN_MAX);
                end
                CMD_READ:
                begin
                    res_weight_reg <= '0;
                    res_count_reg  <= m_range_reg ? cur : '0;
                    res_sat_reg    <= m_range_reg && (cur == BIN_MAX);
                end
                default:
                begin
                    res_weight_reg <= '0;
                    res_count_reg  <= '0;
                    res_sat_reg    <= 1'b0;
                end
            endcase
        end
    end

    assign status.clearing = clearing_reg;
    assign status.take     = take;

    assign result.valid     = res_valid_reg;
    assign result.weight    = res_weight_reg;
    assign result.bin_count = res_count_reg;
    assign result.saturated = res_sat_reg;

endmodule

`default_nettype wire

@@ rtl/dual_code_weight_histogram.sv @@
// Top level: request decode, configuration registers, row of column cells
// and histogram stage. Uses dcwh_pkg, dcwh_if, dcwh_cell and dcwh_hist.
//
//   channel   dir   handshake         carries
//   command   in    valid/ready       cmd, column_index, column_value, word, bin_index
//   result    out   valid/ready       weight, bin_count, saturated
//   apb       in    psel/penable      used_columns (0x0), used_check_bits (0x4)
//
// One request per cycle while result.ready stays high; each result passes
// through 16 column cells, one histogram read stage and one output register.
// After reset a clearing pass zeroes all 543 histogram bins, during
// which command.ready stays low; configuration writes are taken as ever.
// A stalled result lets bubbles in the row close up, so requests keep
// entering until every stage is full.
`default_nettype none

module dual_code_weight_histogram import dcwh_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    dcwh_cmd_if.sink               command,
    dcwh_res_if.source             result
);

    logic [UCOLS_W-1:0]    used_columns_reg;
    logic [UBITS_W-1:0]    used_check_bits_reg;
    logic [UCOLS_W-1:0]    cols_eff;
    logic [UBITS_W-1:0]    bits_eff;
    logic [CHECK_BITS-1:0] word_mask;
    logic [CHECK_BITS-1:0] t;
    logic                  cfg_write;

    dcwh_item_t        head_item;
    dcwh_item_t        cell_item [CELLS];
    logic [CELLS-1:0]  cell_valid;
    logic [CELLS:0]    adv;
    dcwh_hist_status_t hist_status;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_columns_reg    <= UCOLS_W'(512);
            used_check_bits_reg <= UBITS_W'(30);
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_USED_COLUMNS:    used_columns_reg    <= pwdata[UCOLS_W-1:0];
                REG_USED_CHECK_BITS: used_check_bits_reg <= pwdata[UBITS_W-1:0];
                default:             used_columns_reg    <= used_columns_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_USED_COLUMNS:    prdata = {{(APB_DW-UCOLS_W){1'b0}}, used_columns_reg};
            REG_USED_CHECK_BITS: prdata = {{(APB_DW-UBITS_W){1'b0}}, used_check_bits_reg};
            default:             prdata = '0;
        endcase
    end

    assign cols_eff = (used_columns_reg > UCOLS_W'(COLUMNS)) ? UCOLS_W'(COLUMNS)
                                                             : used_columns_reg;
    assign bits_eff = (used_check_bits_reg > UBITS_W'(CHECK_BITS)) ? UBITS_W'(CHECK_BITS)
                                                                   : used_check_bits_reg;

    always_comb
    begin
        for (int i = 0; i < CHECK_BITS; i++)
        begin
            word_mask[i] = (UBITS_W'(i) < bits_eff);
        end
    end

    assign t = command.word & word_mask;

    // Request decode; a zero word touches no bin
    always_comb
    begin
        head_item.col_idx = command.column_index;
        head_item.col_val = command.column_value;
        head_item.word    = t;
        head_item.weight  = {{(WEIGHT_W-6){1'b0}}, ones32({{(32-CHECK_BITS){1'b0}}, t})};
        head_item.bin     = command.bin_index;
        case (command.cmd)
            CMD_LOAD:  head_item.kind = CMD_LOAD;
            CMD_COUNT: head_item.kind = (t == '0) ? CMD_NONE : CMD_COUNT;
            CMD_READ:  head_item.kind = CMD_READ;
            default:   head_item.kind = CMD_NONE;
        endcase
    end

    assign command.ready = adv[0] && !hist_status.clearing;

    // Stage advance: a stage may load when empty or when it empties this cycle
    assign adv[CELLS] = hist_status.take;

    genvar k;
    generate
        for (k = 0; k < CELLS; k++)
        begin : g_cell
            assign adv[k] = !cell_valid[k] || adv[k+1];

            if (k == 0)
            begin : g_first
                dcwh_cell u_cell
                (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .cell_id  (CELL_ID_W'(k)),
                    .used_cols(cols_eff),
                    .adv      (adv[k]),
                    .up_valid (command.valid && !hist_status.clearing),
                    .up_item  (head_item),
                    .dn_valid (cell_valid[k]),
                    .dn_item  (cell_item[k])
                );
            end
            else
            begin : g_rest
                dcwh_cell u_cell
                (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .cell_id  (CELL_ID_W'(k)),
                    .used_cols(cols_eff),
                    .adv      (adv[k]),
                    .up_valid (cell_valid[k-1]),
                    .up_item  (cell_item[k-1]),
                    .dn_valid (cell_valid[k]),
                    .dn_item  (cell_item[k])
                );
            end
        end
    endgenerate

    dcwh_hist u_hist
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .up_valid(cell_valid[CELLS-1]),
        .up_item (cell_item[CELLS-1]),
        .status  (hist_status),
        .result  (result)
    );

    // Nothing may be in the row while the histogram is being cleared
    a_empty_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        hist_status.clearing |-> (cell_valid == '0))
        else $error("request in flight during histogram clear");

    // A count result carries no bin content
    a_count_no_bin: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.weight != '0)) |-> (result.bin_count == '0))
        else $error("count result with non-zero bin_count");

    // Saturation is reported only for a count or for a full bin read
    a_sat_source: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.saturated)
            |-> ((result.weight != '0) || (result.bin_count == BIN_MAX)))
        else $error("saturated flag without a full bin");

    // Weight always addresses a histogram bin
    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ({1'b0, result.weight} < (WEIGHT_W+1)'(HIST_DEPTH)))
        else $error("weight beyond histogram depth");

endmodule

`default_nettype wire

@@ verif/tb_dual_code_weight_histogram.sv @@
// Self-checking testbench for dual_code_weight_histogram: random and directed requests
// against a cycle-free predictor of the column store and weight histogram.
// Depends on dcwh_pkg, dcwh_if and the RTL top level.
module tb_dual_code_weight_histogram;
    import dcwh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = 40;
    localparam int QUEUE_DEPTH = 6;

    localparam logic [APB_AW-1:0] ADDR_USED_COLUMNS    = {2'b00, REG_USED_COLUMNS} << 2;
    localparam logic [APB_AW-1:0] ADDR_USED_CHECK_BITS = {2'b00, REG_USED_CHECK_BITS} << 2;

    typedef struct {
        logic [CMD_W-1:0]      cmd;
        logic [COL_IDX_W-1:0]  column_index;
        logic [CHECK_BITS-1:0] column_value;
        logic [CHECK_BITS-1:0] word;
        logic [BIN_W-1:0]      bin_index;
    } request_t;

    typedef struct {
        logic [WEIGHT_W-1:0] weight;
        logic [COUNT_W-1:0]  bin_count;
        logic                saturated;
    } outcome_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    dcwh_cmd_if req_ch ();
    dcwh_res_if res_ch ();

    dual_code_weight_histogram u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .command (req_ch),
        .result  (res_ch)
    );

    // Predictor state
    logic [CHECK_BITS-1:0] column_copy [COLUMNS]    = '{default: '0};
    logic [COUNT_W-1:0]    bin_copy    [HIST_DEPTH] = '{default: '0};
    bit                    bin_touched [HIST_DEPTH] = '{default: 1'b0};
    int                    touched_bins [$];
    int unsigned           cfg_cols = COLUMNS;
    int unsigned           cfg_bits = CHECK_BITS;

    request_t pending_requests [$];
    outcome_t expected_results [$];

    bit calm;
    bit req_fire;
    bit res_fire;
    int results_seen;
    int mismatches;
    int send_gap;
    int ready_gap;
    bit long_hold_done;
    int cycle_count;

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 86)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [31:0] bit_pattern();
        logic [CHECK_BITS-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = '1;
            1:       v = CHECK_BITS'(1) << $urandom_range(0, CHECK_BITS - 1);
            2:       v = CHECK_BITS'($urandom & $urandom & $urandom);
            3:       v = CHECK_BITS'($urandom_range(0, 15));
            4:       v = ~(CHECK_BITS'(1) << $urandom_range(0, CHECK_BITS - 1));
            default: v = CHECK_BITS'($urandom);
        endcase
        return {{(32-CHECK_BITS){1'b0}}, v};
    endfunction

    function automatic request_t make_request(logic [CMD_W-1:0] cmd,
                                              int unsigned idx, logic [31:0] val,
                                              logic [31:0] word, int unsigned bin);
        request_t r;
        r.cmd          = cmd;
        r.column_index = COL_IDX_W'(idx);
        r.column_value = CHECK_BITS'(val);
        r.word         = CHECK_BITS'(word);
        r.bin_index    = BIN_W'(bin);
        return r;
    endfunction

    function automatic request_t random_request();
        request_t r;
        int       pick;
        r    = make_request(CMD_NONE, $urandom, $urandom, bit_pattern(), $urandom);
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            r.cmd          = CMD_LOAD;
            r.column_value = CHECK_BITS'(bit_pattern());
        end
        else if (pick < 72)
            r.cmd = CMD_COUNT;
        else if (pick < 94)
        begin
            r.cmd = CMD_READ;
            pick  = $urandom_range(0, 9);
            if (pick < 5 && touched_bins.size() != 0)
                r.bin_index = BIN_W'(touched_bins[$urandom_range(0, touched_bins.size() - 1)]);
            else if (pick < 8)
                r.bin_index = BIN_W'($urandom_range(0, HIST_DEPTH - 1));
            else if (pick == 8)
                r.bin_index = BIN_W'($urandom_range(HIST_DEPTH, (1 << BIN_W) - 1));
            else
                r.bin_index = BIN_W'($urandom_range(0, 1) ? 0 : HIST_DEPTH - 1);
        end
        return r;
    endfunction

    // Work out the result of one accepted request and advance the copy of the state
    function automatic outcome_t predict_request(request_t r);
        outcome_t              o;
        logic [CHECK_BITS-1:0] all_ones;
        logic [CHECK_BITS-1:0] t;
        int unsigned           n_bits;
        int unsigned           n_cols;
        int                    w;
        o        = '{weight: '0, bin_count: '0, saturated: 1'b0};
        all_ones = '1;
        case (r.cmd)
            CMD_LOAD:
                column_copy[r.column_index] = r.column_value;
            CMD_COUNT:
            begin
                n_bits = (cfg_bits > CHECK_BITS) ? CHECK_BITS : cfg_bits;
                n_cols = (cfg_cols > COLUMNS) ? COLUMNS : cfg_cols;
                t      = r.word & (all_ones >> (CHECK_BITS - n_bits));
                if (t != '0)
                begin
                    w = $countones(t);
                    for (int i = 0; i < n_cols; i++)
                        w += int'(^(t & column_copy[i]));
                    if (bin_copy[w] != BIN_MAX)
                        bin_copy[w] = bin_copy[w] + 1'b1;
                    o.saturated = (bin_copy[w] == BIN_MAX);
                    o.weight    = WEIGHT_W'(w);
                    if (!bin_touched[w])
                    begin
                        bin_touched[w] = 1'b1;
                        touched_bins.push_back(w);
                    end
                end
            end
            CMD_READ:
                if (r.bin_index < HIST_DEPTH)
                begin
                    o.bin_count = bin_copy[r.bin_index];
                    o.saturated = (bin_copy[r.bin_index] == BIN_MAX);
                end
            default: ;
        endcase
        return o;
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        mismatches++;
    endtask

    // Request side: hold each request until taken, then idle for a random gap
    always @(negedge clk)
    begin
        request_t nxt;
        if (req_ch.valid && !req_fire)
        begin
        end
        else if (send_gap > 0)
        begin
            req_ch.valid <= 1'b0;
            send_gap     <= send_gap - 1;
        end
        else if (pending_requests.size() != 0)
        begin
            nxt = pending_requests.pop_front();
            req_ch.cmd          <= nxt.cmd;
            req_ch.column_index <= nxt.column_index;
            req_ch.column_value <= nxt.column_value;
            req_ch.word         <= nxt.word;
            req_ch.bin_index    <= nxt.bin_index;
            req_ch.valid        <= 1'b1;
            send_gap            <= calm ? 0 : pick_gap();
        end
        else
            req_ch.valid <= 1'b0;
    end

    // Result side: random stalls, plus one long hold-off while requests keep coming
    always @(negedge clk)
    begin
        int g;
        if (!long_hold_done && results_seen >= 300 && pending_requests.size() != 0)
        begin
            res_ch.ready   <= 1'b0;
            ready_gap      <= LONG_HOLD;
            long_hold_done <= 1'b1;
        end
        else if (ready_gap > 0)
        begin
            res_ch.ready <= 1'b0;
            ready_gap    <= ready_gap - 1;
        end
        else
        begin
            g = calm ? 0 : pick_gap();
            res_ch.ready <= (g == 0);
            if (g != 0)
                ready_gap <= g - 1;
        end
    end

    always @(posedge clk)
    begin
        outcome_t want;
        req_fire = rst_n && req_ch.valid && req_ch.ready;
        res_fire = rst_n && res_ch.valid && res_ch.ready;
        if (req_fire)
            expected_results.push_back(predict_request('{req_ch.cmd, req_ch.column_index,
                req_ch.column_value, req_ch.word, req_ch.bin_index}));
        if (res_fire)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $display("%0t ns: result with no request outstanding, weight %0d count %0d",
                         $time, res_ch.weight, res_ch.bin_count);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (res_ch.weight !== want.weight)
                    report_mismatch("weight", want.weight, res_ch.weight);
                if (res_ch.bin_count !== want.bin_count)
                    report_mismatch("bin_count", want.bin_count, res_ch.bin_count);
                if (res_ch.saturated !== want.saturated)
                    report_mismatch("saturated", want.saturated, res_ch.saturated);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_dual_code_weight_histogram: errors");
            $finish;
        end
    end

    task automatic apb_transfer(input bit write, input logic [APB_AW-1:0] addr,
                                input logic [APB_DW-1:0] data, output logic [APB_DW-1:0] got);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reg_check(input logic [APB_AW-1:0] addr, input int unsigned want);
        logic [APB_DW-1:0] got;
        apb_transfer(1'b0, addr, $urandom, got);
        if (got !== want)
            report_mismatch($sformatf("register 0x%0h", addr), want, got);
    endtask

    task automatic send(input request_t r);
        while (pending_requests.size() >= QUEUE_DEPTH)
            @(posedge clk);
        pending_requests.push_back(r);
    endtask

    task automatic drain_results();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || req_ch.valid || expected_results.size() != 0);
    endtask

    // Change the registers only once the block has gone quiet; upper data bits are junk
    task automatic apply_settings(input int unsigned cols, input int unsigned bits);
        logic [APB_DW-1:0] unused;
        drain_results();
        apb_transfer(1'b1, ADDR_USED_COLUMNS,
                     ($urandom & ~32'h3FF) | (cols & 32'h3FF), unused);
        cfg_cols = cols & 32'h3FF;
        apb_transfer(1'b1, ADDR_USED_CHECK_BITS,
                     ($urandom & ~32'h1F) | (bits & 32'h1F), unused);
        cfg_bits = bits & 32'h1F;
        reg_check(ADDR_USED_COLUMNS, cfg_cols);
        reg_check(ADDR_USED_CHECK_BITS, cfg_bits);
    endtask

    initial
    begin
        int          order [COLUMNS];
        int          j;
        int          tmp;
        int unsigned phase_cols [9];
        int unsigned phase_bits [9];
        logic [31:0] ones;

        ones            = {{(32-CHECK_BITS){1'b0}}, {CHECK_BITS{1'b1}}};
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        req_ch.valid    = 1'b0;
        req_ch.cmd      = CMD_NONE;
        req_ch.column_index = '0;
        req_ch.column_value = '0;
        req_ch.word     = '0;
        req_ch.bin_index = '0;
        res_ch.ready    = 1'b0;
        calm            = 1'b0;
        req_fire        = 1'b0;
        res_fire        = 1'b0;
        results_seen    = 0;
        mismatches      = 0;
        send_gap        = 0;
        ready_gap       = 0;
        long_hold_done  = 1'b0;
        cycle_count     = 0;

        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        reg_check(ADDR_USED_COLUMNS, cfg_cols);
        reg_check(ADDR_USED_CHECK_BITS, cfg_bits);

        // Directed: load the low columns and the top one, zero word, bins at and past the end
        send(make_request(CMD_LOAD, 0, ones, $urandom, $urandom));
        send(make_request(CMD_LOAD, 1, '0, $urandom, $urandom));
        for (int i = 2; i < 8; i++)
            send(make_request(CMD_LOAD, i, $urandom, $urandom, $urandom));
        send(make_request(CMD_LOAD, COLUMNS - 1, ones, ones, (1 << BIN_W) - 1));
        send(make_request(CMD_COUNT, $urandom, $urandom, '0, $urandom));
        send(make_request(CMD_READ, $urandom, $urandom, $urandom, 0));
        send(make_request(CMD_READ, $urandom, $urandom, $urandom, HIST_DEPTH - 1));
        send(make_request(CMD_READ, $urandom, $urandom, $urandom, HIST_DEPTH));
        send(make_request(CMD_READ, $urandom, $urandom, $urandom, (1 << BIN_W) - 1));
        send(make_request(CMD_NONE, COLUMNS - 1, ones, ones, (1 << BIN_W) - 1));
        send(make_request(CMD_NONE, $urandom, $urandom, $urandom, $urandom));

        // No columns, one check bit: the upper word bits drop out
        apply_settings(0, 1);
        send(make_request(CMD_COUNT, $urandom, $urandom, ones, $urandom));
        send(make_request(CMD_COUNT, $urandom, $urandom, ones - 1'b1, $urandom));
        send(make_request(CMD_COUNT, $urandom, $urandom, 1, $urandom));
        send(make_request(CMD_READ, $urandom, $urandom, $urandom, 1));

        // Check-bit count above the word width acts as the full width
        apply_settings(8, 31);
        send(make_request(CMD_COUNT, $urandom, $urandom, ones, $urandom));
        send(make_request(CMD_COUNT, $urandom, $urandom, 1, $urandom));
        send(make_request(CMD_COUNT, $urandom, $urandom, ones ^ (ones >> 1), $urandom));
        send(make_request(CMD_READ, $urandom, $urandom, $urandom, 1));

        // Zero check bits: every word masks to zero
        apply_settings(8, 0);
        send(make_request(CMD_COUNT, $urandom, $urandom, ones, $urandom));

        // Fill the whole column store in shuffled order, mixed with other requests
        apply_settings(8, 30);
        for (int i = 0; i < COLUMNS; i++)
            order[i] = i;
        for (int i = COLUMNS - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < COLUMNS; i++)
        begin
            send(make_request(CMD_LOAD, order[i], bit_pattern(), $urandom, $urandom));
            if ($urandom_range(0, 99) < 30)
                send(random_request());
        end

        phase_cols = '{COLUMNS, 1023, COLUMNS + 1, 1, 0, 300, 100,
                       $urandom_range(0, 1023), $urandom_range(0, 1023)};
        phase_bits = '{CHECK_BITS, 31, 17, CHECK_BITS, 5, 0, 12,
                       $urandom_range(0, 31), $urandom_range(0, 31)};
        for (int p = 0; p < 9; p++)
        begin
            apply_settings(phase_cols[p], phase_bits[p]);
            calm = (p == 2 || p == 6);
            for (int k = 0; k < 85; k++)
            begin
                // pause the sender mid-phase until every result is back
                if (p == 0 && k == 40)
                    drain_results();
                send(random_request());
            end
        end

        drain_results();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (mismatches == 0)
            $display("tb_dual_code_weight_histogram: clean");
        else
            $display("tb_dual_code_weight_histogram: errors");
        $finish;
    end

endmodule
